@@ hw/rtl/cbas_pkg.sv @@
package cbas_pkg;

  // timing constants
  localparam int unsigned TICK_MS   = 10;
  localparam int unsigned PWM_STEPS = 10;

  // widths
  localparam int unsigned TICK_W = 13;
  localparam int unsigned MS_W   = 16;
  localparam int unsigned PWM_W  = 4;
  localparam int unsigned CFG_W  = 13;

  localparam logic [TICK_W-1:0] MAX_TICKS = {TICK_W{1'b1}};

  // ms to ticks by reciprocal multiply, exact for 16-bit input and divisors up to 128
  localparam int unsigned RECIP_SHIFT = MS_W + 7;
  localparam int unsigned RECIP_W     = RECIP_SHIFT + 1;
  localparam int unsigned PROD_W      = MS_W + RECIP_W;
  localparam logic [RECIP_W-1:0] RECIP_MUL =
    RECIP_W'((64'd1 << RECIP_SHIFT) + 64'(TICK_MS) - 64'd1) / RECIP_W'(TICK_MS);

  // reset values
  localparam logic [TICK_W-1:0] DELAY_RST = TICK_W'(10);
  localparam logic [TICK_W-1:0] HOLD_RST  = TICK_W'(500);

  // beat opcodes
  typedef enum logic [1:0] {
    OP_TICK   = 2'd0,
    OP_CLUTCH = 2'd1,
    OP_BRAKE  = 2'd2,
    OP_PWM    = 2'd3
  } op_e;

  // command codes; the fourth code carries no name of its own
  localparam logic [1:0] CMD_OFF   = 2'd0;
  localparam logic [1:0] CMD_ON    = 2'd1;
  localparam logic [1:0] CMD_COAST = 2'd2;

  // indicator codes
  localparam logic [1:0] IND_NONE  = 2'd0;
  localparam logic [1:0] IND_BRAKE = 2'd1;
  localparam logic [1:0] IND_COAST = 2'd2;

  // configuration register indexes
  typedef enum logic [1:0] {
    REG_STAGED_BRAKE = 2'd0,
    REG_PWM_CLUTCH   = 2'd1,
    REG_CLUTCH_DUTY  = 2'd2,
    REG_HOLD_TICKS   = 2'd3
  } reg_e;

  // staged brake phases
  typedef enum logic [1:0] {
    PH_BRAKING   = 2'd0,
    PH_COASTING  = 2'd1,
    PH_RELEASING = 2'd2,
    PH_LOCKED    = 2'd3
  } phase_e;

  // one result beat
  typedef struct packed {
    logic       clutch_drive;
    logic       brake_pin_high;
    logic       valve_a;
    logic       valve_b;
    logic [1:0] indicator;
  } result_t;

  // fifo handshake toward the top level
  typedef struct packed {
    logic full;
    logic empty;
  } fifo_status_t;

endpackage

@@ hw/rtl/cbas_out_fifo.sv @@
module cbas_out_fifo (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  push_i,
  input  cbas_pkg::result_t     push_data_i,
  input  logic                  pop_i,
  output cbas_pkg::result_t     pop_data_o,
  output cbas_pkg::fifo_status_t status_o
);

  cbas_pkg::result_t entry_q [2];
  logic       wr_ptr_q;
  logic       rd_ptr_q;
  logic [1:0] cnt_q;
  logic [1:0] cnt_d;

  // occupancy
  always_comb begin
    cnt_d = cnt_q;
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 2'd1;
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - 2'd1;
    end
  end

  // pointers and count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      cnt_q <= cnt_d;
      if (push_i) begin
        wr_ptr_q <= ~wr_ptr_q;
      end
      if (pop_i) begin
        rd_ptr_q <= ~rd_ptr_q;
      end
    end
  end

  // storage
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wr_ptr_q] <= push_data_i;
    end
  end

  assign pop_data_o     = entry_q[rd_ptr_q];
  assign status_o.full  = (cnt_q == 2'd2);
  assign status_o.empty = (cnt_q == 2'd0);

endmodule

@@ hw/rtl/clutch_brake_actuator_sequencer.sv @@
// The result of an accepted input beat is written into the result queue and reaches the output from there.
// Throughput: one beat per cycle; a two-entry result queue lets a new beat in
// while one result waits, and input stalls only when both entries are taken.
// Reset (asynchronous, active low): delays 10 ticks, brake phase braking, applied
// brake on, held levels clutch off, brake pin high, valves off, indicator none.
module clutch_brake_actuator_sequencer (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [1:0]                    op_i,
  input  logic [1:0]                    command_i,
  input  logic [cbas_pkg::MS_W-1:0]     delay_ms_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic                          clutch_drive_o,
  output logic                          brake_pin_high_o,
  output logic                          valve_a_o,
  output logic                          valve_b_o,
  output logic [1:0]                    indicator_o,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [1:0]                    cfg_index_i,
  input  logic [cbas_pkg::CFG_W-1:0]    cfg_data_i
);

  // configuration
  logic                            staged_q;
  logic                            pwm_q;
  logic [cbas_pkg::PWM_W-1:0]      duty_q;
  logic [cbas_pkg::TICK_W-1:0]     hold_ticks_q;

  // sequencer state
  logic [cbas_pkg::TICK_W-1:0] clutch_delay_q, clutch_delay_d;
  logic                        clutch_cmd_q, clutch_cmd_d;
  logic                        relay_q, relay_d;
  logic [cbas_pkg::PWM_W-1:0]  pwm_step_q, pwm_step_d;
  logic [cbas_pkg::TICK_W-1:0] brake_delay_q, brake_delay_d;
  logic                        expired_q, expired_d;
  logic [1:0]                  brake_cmd_q, brake_cmd_d;
  logic [1:0]                  applied_q, applied_d;
  cbas_pkg::phase_e            phase_q, phase_d;
  logic [cbas_pkg::TICK_W-1:0] hold_q, hold_d;
  cbas_pkg::result_t           lvl_q, lvl_d;

  // staged machine signals
  logic [1:0]                  pact;
  cbas_pkg::phase_e            fsm_phase_nx;
  logic [cbas_pkg::TICK_W-1:0] fsm_hold_nx;
  cbas_pkg::result_t           fsm_lvl;

  // delay conversion
  logic [cbas_pkg::PROD_W-1:0] tick_prod;
  logic [cbas_pkg::MS_W-1:0]   tick_quot;
  logic [cbas_pkg::TICK_W-1:0] ticks;

  logic                  push;
  logic                  pop;
  cbas_pkg::result_t     out_data;
  cbas_pkg::fifo_status_t fifo_st;
  cbas_pkg::op_e         op;

  assign op          = cbas_pkg::op_e'(op_i);
  assign push        = in_valid_i && !in_stall_o;
  assign pop         = out_valid_o && !out_stall_i;
  assign in_stall_o  = fifo_st.full;
  assign out_valid_o = !fifo_st.empty;
  assign cfg_ready_o = 1'b1;

  // configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      staged_q     <= 1'b1;
      pwm_q        <= 1'b0;
      duty_q       <= '0;
      hold_ticks_q <= cbas_pkg::HOLD_RST;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cbas_pkg::reg_e'(cfg_index_i))
        cbas_pkg::REG_STAGED_BRAKE: staged_q     <= cfg_data_i[0];
        cbas_pkg::REG_PWM_CLUTCH:   pwm_q        <= cfg_data_i[0];
        cbas_pkg::REG_CLUTCH_DUTY:  duty_q       <= cfg_data_i[cbas_pkg::PWM_W-1:0];
        cbas_pkg::REG_HOLD_TICKS:   hold_ticks_q <= cfg_data_i[cbas_pkg::TICK_W-1:0];
        default: ;
      endcase
    end
  end

  // milliseconds to control ticks, saturated
  always_comb begin
    tick_prod = cbas_pkg::PROD_W'(delay_ms_i) * cbas_pkg::PROD_W'(cbas_pkg::RECIP_MUL);
    tick_quot = tick_prod[cbas_pkg::RECIP_SHIFT +: cbas_pkg::MS_W];
    if (tick_quot > cbas_pkg::MS_W'(cbas_pkg::MAX_TICKS)) begin
      ticks = cbas_pkg::MAX_TICKS;
    end else begin
      ticks = tick_quot[cbas_pkg::TICK_W-1:0];
    end
  end

  // brake command seen by the staged machine on this tick
  always_comb begin
    if (!expired_q && brake_delay_q == '0) begin
      pact = brake_cmd_q;
    end else begin
      pact = applied_q;
    end
  end

  // staged machine: next phase and hold count
  always_comb begin
    fsm_phase_nx = phase_q;
    fsm_hold_nx  = hold_q;
    case (phase_q)
      cbas_pkg::PH_BRAKING: begin
        if (pact == cbas_pkg::CMD_OFF) begin
          fsm_phase_nx = cbas_pkg::PH_RELEASING;
          fsm_hold_nx  = '0;
        end else if (pact == cbas_pkg::CMD_COAST) begin
          fsm_phase_nx = cbas_pkg::PH_COASTING;
        end
      end
      cbas_pkg::PH_COASTING: begin
        if (pact == cbas_pkg::CMD_ON) begin
          fsm_phase_nx = cbas_pkg::PH_BRAKING;
        end else if (pact == cbas_pkg::CMD_OFF) begin
          fsm_phase_nx = cbas_pkg::PH_RELEASING;
          fsm_hold_nx  = '0;
        end
      end
      cbas_pkg::PH_RELEASING: begin
        if (hold_q >= hold_ticks_q) begin
          fsm_phase_nx = cbas_pkg::PH_LOCKED;
        end else if (hold_q != cbas_pkg::MAX_TICKS) begin
          fsm_hold_nx = hold_q + cbas_pkg::TICK_W'(1);
        end
        if (pact == cbas_pkg::CMD_ON || pact == cbas_pkg::CMD_COAST) begin
          fsm_phase_nx = cbas_pkg::PH_BRAKING;
        end
      end
      default: begin
        if (pact == cbas_pkg::CMD_ON || pact == cbas_pkg::CMD_COAST) begin
          fsm_phase_nx = cbas_pkg::PH_BRAKING;
        end
      end
    endcase
  end

  // staged machine: levels driven from the current phase
  always_comb begin
    fsm_lvl.clutch_drive = 1'b0;
    case (phase_q)
      cbas_pkg::PH_BRAKING: begin
        fsm_lvl.brake_pin_high = 1'b1;
        fsm_lvl.valve_a        = 1'b0;
        fsm_lvl.valve_b        = 1'b0;
        fsm_lvl.indicator      = cbas_pkg::IND_BRAKE;
      end
      cbas_pkg::PH_COASTING: begin
        fsm_lvl.brake_pin_high = 1'b1;
        fsm_lvl.valve_a        = 1'b1;
        fsm_lvl.valve_b        = 1'b0;
        fsm_lvl.indicator      = cbas_pkg::IND_COAST;
      end
      cbas_pkg::PH_RELEASING: begin
        fsm_lvl.brake_pin_high = 1'b1;
        fsm_lvl.valve_a        = 1'b1;
        fsm_lvl.valve_b        = 1'b1;
        fsm_lvl.indicator      = cbas_pkg::IND_NONE;
      end
      default: begin
        fsm_lvl.brake_pin_high = 1'b0;
        fsm_lvl.valve_a        = 1'b0;
        fsm_lvl.valve_b        = 1'b0;
        fsm_lvl.indicator      = cbas_pkg::IND_NONE;
      end
    endcase
  end

  // per-beat state update
  always_comb begin
    clutch_delay_d = clutch_delay_q;
    clutch_cmd_d   = clutch_cmd_q;
    relay_d        = relay_q;
    pwm_step_d     = pwm_step_q;
    brake_delay_d  = brake_delay_q;
    expired_d      = expired_q;
    brake_cmd_d    = brake_cmd_q;
    applied_d      = applied_q;
    phase_d        = phase_q;
    hold_d         = hold_q;
    lvl_d          = lvl_q;
    case (op)
      cbas_pkg::OP_TICK: begin
        // clutch delay countdown
        if (clutch_delay_q != '0) begin
          clutch_delay_d = clutch_delay_q - cbas_pkg::TICK_W'(1);
        end else if (pwm_q) begin
          relay_d = clutch_cmd_q;
        end else begin
          lvl_d.clutch_drive = clutch_cmd_q;
        end
        if (staged_q) begin
          // hand the command over once, then run the phase machine
          if (!expired_q) begin
            if (brake_delay_q == '0) begin
              applied_d = brake_cmd_q;
              expired_d = 1'b1;
            end else begin
              brake_delay_d = brake_delay_q - cbas_pkg::TICK_W'(1);
            end
          end
          phase_d              = fsm_phase_nx;
          hold_d               = fsm_hold_nx;
          lvl_d.brake_pin_high = fsm_lvl.brake_pin_high;
          lvl_d.valve_a        = fsm_lvl.valve_a;
          lvl_d.valve_b        = fsm_lvl.valve_b;
          lvl_d.indicator      = fsm_lvl.indicator;
        end else begin
          // plain brake: an expired count reads as zero and reapplies every tick
          expired_d = 1'b0;
          if (!expired_q && brake_delay_q != '0) begin
            brake_delay_d = brake_delay_q - cbas_pkg::TICK_W'(1);
          end else begin
            brake_delay_d        = '0;
            lvl_d.brake_pin_high = (brake_cmd_q != cbas_pkg::CMD_OFF);
          end
          lvl_d.indicator = cbas_pkg::IND_NONE;
        end
      end
      cbas_pkg::OP_CLUTCH: begin
        clutch_delay_d = ticks;
        clutch_cmd_d   = (command_i != cbas_pkg::CMD_OFF);
        if (delay_ms_i == '0 &&
            (command_i == cbas_pkg::CMD_ON || command_i == cbas_pkg::CMD_OFF)) begin
          if (pwm_q) begin
            relay_d = (command_i == cbas_pkg::CMD_ON);
          end else begin
            lvl_d.clutch_drive = (command_i == cbas_pkg::CMD_ON);
          end
        end
      end
      cbas_pkg::OP_BRAKE: begin
        brake_delay_d = ticks;
        expired_d     = 1'b0;
        brake_cmd_d   = command_i;
        if (delay_ms_i == '0) begin
          if (command_i == cbas_pkg::CMD_ON) begin
            lvl_d.brake_pin_high = 1'b1;
            if (staged_q) begin
              lvl_d.valve_a = 1'b0;
              lvl_d.valve_b = 1'b0;
            end
          end
          if (command_i == cbas_pkg::CMD_OFF && !staged_q) begin
            lvl_d.brake_pin_high = 1'b0;
          end
        end
      end
      default: begin
        // millisecond pwm tick
        if (pwm_q) begin
          if (relay_q) begin
            lvl_d.clutch_drive = (pwm_step_q < duty_q);
            if (pwm_step_q == cbas_pkg::PWM_W'(cbas_pkg::PWM_STEPS - 1)) begin
              pwm_step_d = '0;
            end else begin
              pwm_step_d = pwm_step_q + cbas_pkg::PWM_W'(1);
            end
          end else begin
            lvl_d.clutch_drive = 1'b0;
          end
        end
      end
    endcase
  end

  // state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clutch_delay_q       <= cbas_pkg::DELAY_RST;
      clutch_cmd_q         <= 1'b0;
      relay_q              <= 1'b0;
      pwm_step_q           <= '0;
      brake_delay_q        <= cbas_pkg::DELAY_RST;
      expired_q            <= 1'b0;
      brake_cmd_q          <= cbas_pkg::CMD_OFF;
      applied_q            <= cbas_pkg::CMD_ON;
      phase_q              <= cbas_pkg::PH_BRAKING;
      hold_q               <= '0;
      lvl_q.clutch_drive   <= 1'b0;
      lvl_q.brake_pin_high <= 1'b1;
      lvl_q.valve_a        <= 1'b0;
      lvl_q.valve_b        <= 1'b0;
      lvl_q.indicator      <= cbas_pkg::IND_NONE;
    end else if (push) begin
      clutch_delay_q <= clutch_delay_d;
      clutch_cmd_q   <= clutch_cmd_d;
      relay_q        <= relay_d;
      pwm_step_q     <= pwm_step_d;
      brake_delay_q  <= brake_delay_d;
      expired_q      <= expired_d;
      brake_cmd_q    <= brake_cmd_d;
      applied_q      <= applied_d;
      phase_q        <= phase_d;
      hold_q         <= hold_d;
      lvl_q          <= lvl_d;
    end
  end

  // result queue
  cbas_out_fifo u_out_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (lvl_d),
    .pop_i       (pop),
    .pop_data_o  (out_data),
    .status_o    (fifo_st)
  );

  assign clutch_drive_o   = out_data.clutch_drive;
  assign brake_pin_high_o = out_data.brake_pin_high;
  assign valve_a_o        = out_data.valve_a;
  assign valve_b_o        = out_data.valve_b;
  assign indicator_o      = out_data.indicator;

  // checks
  a_result_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push |=> out_valid_o)
    else $error("accepted beat left no result");

  a_pwm_off_holds_clutch: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push && op == cbas_pkg::OP_PWM && !pwm_q) |=> $stable(lvl_q.clutch_drive))
    else $error("pwm beat moved the clutch with pwm disabled");

  a_indicator_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    lvl_q.indicator != 2'd3)
    else $error("indicator holds an undefined code");

  a_plain_no_indicator: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push && op == cbas_pkg::OP_TICK && !staged_q) |=> lvl_q.indicator == cbas_pkg::IND_NONE)
    else $error("plain brake tick left an indicator code");

endmodule

@@ tb/sv/testbench.sv @@
module testbench;
  import cbas_pkg::*;

  // command code with no name of its own in the package
  localparam logic [1:0] CMD_SPARE = 2'd3;
  localparam int unsigned CYCLE_LIMIT = 500000;
  localparam int unsigned RANDOM_ITEMS = 600;

  // clock, reset and block ports
  logic clk = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [1:0] op_in = 2'd0;
  logic [1:0] cmd_in = 2'd0;
  logic [MS_W-1:0] ms_in = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic clutch_drive, brake_pin_high, valve_a, valve_b;
  logic [1:0] indicator;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [1:0] cfg_index = 2'd0;
  logic [CFG_W-1:0] cfg_data = '0;

  // idling control and bookkeeping
  bit calm = 1'b0;
  int stall_run = 0;
  int stall_pick;
  int failures = 0;
  int checked = 0;
  int settings_count = 0;
  int op_count[4] = '{default: 0};
  result_t expected_levels[$];
  result_t seen, want;

  // predicted configuration
  logic staged_mode = 1'b1;
  logic pwm_mode = 1'b0;
  logic [PWM_W-1:0] duty = '0;
  logic [TICK_W-1:0] hold_limit = HOLD_RST;

  // predicted clutch and brake state
  logic [TICK_W-1:0] clutch_wait = DELAY_RST;
  logic clutch_target = 1'b0;
  logic relay_on = 1'b0;
  logic [PWM_W-1:0] pwm_pos = '0;
  logic [TICK_W:0] brake_wait = 14'd10;
  logic brake_done = 1'b0;
  logic [1:0] brake_target = CMD_OFF;
  logic [1:0] brake_latched = CMD_ON;
  phase_e phase = PH_BRAKING;
  logic [TICK_W-1:0] hold_cnt = '0;
  result_t levels = '{clutch_drive: 1'b0, brake_pin_high: 1'b1, valve_a: 1'b0,
                      valve_b: 1'b0, indicator: IND_NONE};

  clutch_brake_actuator_sequencer u_dut (
    .clk_i            (clk),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid),
    .in_stall_o       (in_stall),
    .op_i             (op_in),
    .command_i        (cmd_in),
    .delay_ms_i       (ms_in),
    .out_valid_o      (out_valid),
    .out_stall_i      (out_stall),
    .clutch_drive_o   (clutch_drive),
    .brake_pin_high_o (brake_pin_high),
    .valve_a_o        (valve_a),
    .valve_b_o        (valve_b),
    .indicator_o      (indicator),
    .cfg_valid_i      (cfg_valid),
    .cfg_ready_o      (cfg_ready),
    .cfg_index_i      (cfg_index),
    .cfg_data_i       (cfg_data)
  );

  // clock
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // hold reset, then release it on a falling edge
  initial begin
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_ni = 1'b1;
  end

  // watchdog
  initial begin : watchdog
    int unsigned cycles;
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("timeout after %0d cycles, %0d results still pending", cycles,
             expected_levels.size());
    $display("TB_ERROR");
    $finish;
  end

  // receiver stalls: mostly short, a few long
  always @(negedge clk) begin
    if (stall_run > 0) begin
      out_stall = 1'b1;
      stall_run--;
    end else begin
      out_stall = 1'b0;
      if (!calm && rst_ni) begin
        stall_pick = $urandom_range(0, 99);
        if (stall_pick < 3) stall_run = $urandom_range(10, 40);
        else if (stall_pick < 20) stall_run = $urandom_range(1, 3);
      end
    end
  end

  // result checker
  always @(posedge clk) begin
    if (rst_ni && out_valid === 1'b1 && out_stall === 1'b0) begin
      seen = {clutch_drive, brake_pin_high, valve_a, valve_b, indicator};
      if (expected_levels.size() == 0) begin
        failures++;
        if (failures <= 10)
          $display("unexpected result beat: clutch %b pin %b va %b vb %b ind %0d",
                   seen.clutch_drive, seen.brake_pin_high, seen.valve_a,
                   seen.valve_b, seen.indicator);
      end else begin
        want = expected_levels.pop_front();
        checked++;
        if (seen !== want) begin
          failures++;
          if (failures <= 10)
            $display("mismatch on result %0d: expected clutch %b pin %b va %b vb %b ind %0d, got clutch %b pin %b va %b vb %b ind %0d",
                     checked, want.clutch_drive, want.brake_pin_high, want.valve_a,
                     want.valve_b, want.indicator, seen.clutch_drive,
                     seen.brake_pin_high, seen.valve_a, seen.valve_b, seen.indicator);
        end
      end
    end
  end

  function automatic logic [TICK_W-1:0] ms_to_ticks(input logic [MS_W-1:0] ms);
    int unsigned t;
    t = 32'(ms) / TICK_MS;
    if (t > 32'(MAX_TICKS)) t = 32'(MAX_TICKS);
    return TICK_W'(t);
  endfunction

  // clutch level goes to the relay in pwm mode, straight to the output otherwise
  function automatic void drive_clutch(input logic on);
    if (pwm_mode) relay_on = on;
    else levels.clutch_drive = on;
  endfunction

  // expected output levels after one accepted input beat
  task automatic advance_levels(input op_e op, input logic [1:0] cmd,
                                input logic [MS_W-1:0] ms, output result_t lv);
    case (op)
      OP_TICK: begin
        if (clutch_wait != 0) clutch_wait--;
        else drive_clutch(clutch_target);
        if (staged_mode) begin
          // expired delay hands the command over once
          if (!brake_done) begin
            if (brake_wait == 0) begin
              brake_latched = brake_target;
              brake_done = 1'b1;
            end else begin
              brake_wait--;
            end
          end
          case (phase)
            PH_BRAKING: begin
              levels.brake_pin_high = 1'b1;
              levels.valve_a = 1'b0;
              levels.valve_b = 1'b0;
              levels.indicator = IND_BRAKE;
              if (brake_latched == CMD_OFF) begin
                phase = PH_RELEASING;
                hold_cnt = '0;
              end
              if (brake_latched == CMD_COAST) phase = PH_COASTING;
            end
            PH_COASTING: begin
              levels.brake_pin_high = 1'b1;
              levels.valve_a = 1'b1;
              levels.valve_b = 1'b0;
              levels.indicator = IND_COAST;
              if (brake_latched == CMD_ON) phase = PH_BRAKING;
              if (brake_latched == CMD_OFF) begin
                phase = PH_RELEASING;
                hold_cnt = '0;
              end
            end
            PH_RELEASING: begin
              levels.brake_pin_high = 1'b1;
              levels.valve_a = 1'b1;
              levels.valve_b = 1'b1;
              levels.indicator = IND_NONE;
              if (hold_cnt >= hold_limit) phase = PH_LOCKED;
              else if (hold_cnt != MAX_TICKS) hold_cnt++;
              if (brake_latched == CMD_ON || brake_latched == CMD_COAST) phase = PH_BRAKING;
            end
            default: begin
              levels.brake_pin_high = 1'b0;
              levels.valve_a = 1'b0;
              levels.valve_b = 1'b0;
              levels.indicator = IND_NONE;
              if (brake_latched == CMD_ON || brake_latched == CMD_COAST) phase = PH_BRAKING;
            end
          endcase
        end else begin
          // plain brake reapplies its command every tick once expired
          if (brake_done) begin
            brake_done = 1'b0;
            brake_wait = '0;
          end
          if (brake_wait != 0) brake_wait--;
          else levels.brake_pin_high = (brake_target != CMD_OFF);
          levels.indicator = IND_NONE;
        end
      end
      OP_CLUTCH: begin
        clutch_wait = ms_to_ticks(ms);
        clutch_target = (cmd != CMD_OFF);
        if (ms == 0 && (cmd == CMD_ON || cmd == CMD_OFF)) drive_clutch(cmd[0]);
      end
      OP_BRAKE: begin
        brake_wait = {1'b0, ms_to_ticks(ms)};
        brake_done = 1'b0;
        brake_target = cmd;
        if (ms == 0) begin
          if (cmd == CMD_ON) begin
            levels.brake_pin_high = 1'b1;
            if (staged_mode) begin
              levels.valve_a = 1'b0;
              levels.valve_b = 1'b0;
            end
          end
          if (cmd == CMD_OFF && !staged_mode) levels.brake_pin_high = 1'b0;
        end
      end
      default: begin
        if (pwm_mode) begin
          if (relay_on) begin
            levels.clutch_drive = (pwm_pos < duty);
            pwm_pos = PWM_W'((32'(pwm_pos) + 1) % PWM_STEPS);
          end else begin
            levels.clutch_drive = 1'b0;
          end
        end
      end
    endcase
    lv = levels;
  endtask

  // send one input beat after a random gap and record its expected result
  task automatic send_beat(input op_e op, input logic [1:0] cmd, input logic [MS_W-1:0] ms);
    int gap;
    int pick;
    result_t lv;
    @(negedge clk);
    gap = 0;
    if (!calm) begin
      pick = $urandom_range(0, 99);
      if (pick < 4) gap = $urandom_range(8, 30);
      else if (pick < 30) gap = $urandom_range(1, 3);
    end
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid = 1'b1;
    op_in = op;
    cmd_in = cmd;
    ms_in = ms;
    do @(posedge clk); while (in_stall);
    advance_levels(op, cmd, ms, lv);
    expected_levels.push_back(lv);
    op_count[op]++;
  endtask

  // tick with random content in the ignored fields
  task automatic send_tick();
    send_beat(OP_TICK, 2'($urandom_range(0, 3)), MS_W'($urandom));
  endtask

  // stop sending and wait until every expected result has come
  task automatic drain_results();
    @(negedge clk);
    in_valid = 1'b0;
    while (expected_levels.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic write_reg(input reg_e idx, input logic [CFG_W-1:0] val);
    @(negedge clk);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data = val;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_STAGED_BRAKE: staged_mode = val[0];
      REG_PWM_CLUTCH:   pwm_mode = val[0];
      REG_CLUTCH_DUTY:  duty = val[PWM_W-1:0];
      default:          hold_limit = val;
    endcase
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  // full register setting, written only once the block is idle
  task automatic apply_setting(input logic staged, input logic pwm, input int unsigned d,
                               input int unsigned hold);
    drain_results();
    write_reg(REG_STAGED_BRAKE, CFG_W'(staged));
    write_reg(REG_PWM_CLUTCH, CFG_W'(pwm));
    write_reg(REG_CLUTCH_DUTY, CFG_W'(d));
    write_reg(REG_HOLD_TICKS, CFG_W'(hold));
    settings_count++;
  endtask

  function automatic logic [1:0] pick_cmd();
    if ($urandom_range(0, 19) == 0) return CMD_SPARE;
    return 2'($urandom_range(0, 2));
  endfunction

  // mostly short delays so that commands expire within a burst
  function automatic logic [MS_W-1:0] pick_delay();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 35) return '0;
    if (pick < 80) return MS_W'($urandom_range(1, 60));
    if (pick < 95) return MS_W'($urandom_range(61, 3000));
    return MS_W'($urandom_range(0, 65535));
  endfunction

  // reset state: both delays run out on the eleventh tick
  task automatic test_power_up();
    send_beat(OP_PWM, CMD_ON, 16'd0);
    repeat (11) send_tick();
  endtask

  // zero-delay commands of every code in staged mode
  task automatic test_immediate_commands();
    send_beat(OP_CLUTCH, CMD_ON, 16'd0);
    send_beat(OP_CLUTCH, CMD_OFF, 16'd0);
    send_beat(OP_CLUTCH, CMD_COAST, 16'd0);
    send_tick();
    send_beat(OP_CLUTCH, CMD_SPARE, 16'd0);
    send_beat(OP_BRAKE, CMD_ON, 16'd0);
    send_beat(OP_BRAKE, CMD_COAST, 16'd0);
    send_tick();
    send_beat(OP_BRAKE, CMD_SPARE, 16'd0);
    send_tick();
    send_beat(OP_BRAKE, CMD_OFF, 16'd0);
  endtask

  // releasing turns into locked after a short hold, longest delay blocks re-brake
  task automatic test_release_lock();
    apply_setting(1'b1, 1'b0, 0, 1);
    send_beat(OP_BRAKE, CMD_OFF, 16'd19);
    repeat (5) send_tick();
    send_beat(OP_BRAKE, CMD_ON, 16'hffff);
    repeat (2) send_tick();
  endtask

  // plain brake with full-duty and zero-duty pwm clutch
  task automatic test_plain_pwm();
    apply_setting(1'b0, 1'b1, PWM_STEPS, 0);
    send_beat(OP_CLUTCH, CMD_ON, 16'd0);
    repeat (3) send_beat(OP_PWM, CMD_OFF, 16'd0);
    send_beat(OP_BRAKE, CMD_OFF, 16'd0);
    send_tick();
    send_beat(OP_BRAKE, CMD_SPARE, 16'd10);
    repeat (2) send_tick();
    drain_results();
    write_reg(REG_CLUTCH_DUTY, '0);
    repeat (2) send_beat(OP_PWM, CMD_ON, 16'd0);
  endtask

  // one burst of mostly well-formed traffic
  task automatic random_burst();
    int kind;
    int n;
    kind = $urandom_range(0, 9);
    if (kind < 4) begin
      send_beat(OP_BRAKE, pick_cmd(), pick_delay());
      n = $urandom_range(1, 12);
      repeat (n) send_tick();
    end else if (kind < 6) begin
      send_beat(OP_CLUTCH, pick_cmd(), pick_delay());
      n = $urandom_range(1, 12);
      repeat (n) begin
        if ($urandom_range(0, 1)) send_tick();
        else send_beat(OP_PWM, 2'($urandom_range(0, 3)), MS_W'($urandom));
      end
    end else if (kind < 8) begin
      n = $urandom_range(5, 25);
      repeat (n) begin
        if ($urandom_range(0, 5) == 0) send_tick();
        else send_beat(OP_PWM, 2'($urandom_range(0, 3)), MS_W'($urandom));
      end
    end else begin
      send_beat(op_e'($urandom_range(0, 3)), 2'($urandom_range(0, 3)),
                MS_W'($urandom_range(0, 65535)));
    end
  endtask

  task automatic test_random_phase(input logic staged, input logic pwm, input int unsigned d,
                                   input int unsigned hold, input bit quiet_run,
                                   input int unsigned n);
    int start;
    apply_setting(staged, pwm, d, hold);
    calm = quiet_run;
    start = op_count.sum();
    while (op_count.sum() - start < n) random_burst();
    calm = 1'b0;
  endtask

  // test sequence
  initial begin
    @(posedge rst_ni);
    test_power_up();
    test_immediate_commands();
    test_release_lock();
    test_plain_pwm();
    test_random_phase(1'b1, 1'b0, 0, 5, 1'b0, RANDOM_ITEMS / 6);
    test_random_phase(1'b1, 1'b1, $urandom_range(0, PWM_STEPS), 0, 1'b0, RANDOM_ITEMS / 6);
    test_random_phase(1'b0, 1'b1, PWM_STEPS, 0, 1'b0, RANDOM_ITEMS / 6);
    test_random_phase(1'b0, 1'b0, 0, 8191, 1'b1, RANDOM_ITEMS / 6);
    test_random_phase(1'b1, 1'b1, 0, 8191, 1'b0, RANDOM_ITEMS / 6);
    test_random_phase(1'b1, 1'b1, $urandom_range(0, PWM_STEPS), $urandom_range(0, 30),
                      1'b0, RANDOM_ITEMS / 6);
    drain_results();
    repeat (5) @(posedge clk);
    if (expected_levels.size() != 0) begin
      failures += expected_levels.size();
      $display("%0d expected results never arrived", expected_levels.size());
    end
    $display("covered %0d ticks, %0d clutch, %0d brake, %0d pwm beats over %0d settings",
             op_count[OP_TICK], op_count[OP_CLUTCH], op_count[OP_BRAKE], op_count[OP_PWM],
             settings_count);
    $display("checked %0d result beats, %0d failures", checked, failures);
    if (failures == 0) $display("TB_OK");
    else $display("TB_ERROR");
    $finish;
  end

endmodule
